[sv/cfc_pkg.sv]
package cfc_pkg;

	localparam int SLOT_COUNT    = 4;
	localparam int SLOT_W        = 2;
	localparam int REG_COUNT     = 4;
	localparam int REG_IDX_W     = 2;
	localparam int ID_W          = 11;
	localparam int LEN_W         = 4;
	localparam int PAYLOAD_BYTES = 8;
	localparam int DATA_W        = 8 * PAYLOAD_BYTES;
	localparam int TS_W          = 32;
	localparam int VAL_W         = 32;
	localparam int CODE_W        = 2;

	localparam logic [LEN_W-1:0] FULL_LENGTH = LEN_W'(PAYLOAD_BYTES);

	localparam logic [CODE_W-1:0] RC_NO_MATCH  = 2'd0;
	localparam logic [CODE_W-1:0] RC_UNCHANGED = 2'd1;
	localparam logic [CODE_W-1:0] RC_UPDATED   = 2'd2;
	localparam logic [CODE_W-1:0] RC_BAD_LEN   = 2'd3;

	localparam logic [SLOT_W-1:0] SLOT_STATUS      = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_CURRENT     = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_VOLTAGE     = 2'd2;
	localparam logic [SLOT_W-1:0] SLOT_TEMPERATURE = 2'd3;

	typedef logic [REG_COUNT-1:0][ID_W-1:0] id_bank_t;

	localparam id_bank_t ID_RESET = {11'h488, 11'h388, 11'h288, 11'h188};

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] data;
		logic [TS_W-1:0]   ts;
	} slot_wr_t;

	function automatic logic [DATA_W-1:0] swap_halves(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int i = 0; i < PAYLOAD_BYTES / 2; i++) begin
			r[8*i +: 8] = v[8*(PAYLOAD_BYTES/2 - 1 - i) +: 8];
			r[8*(PAYLOAD_BYTES/2 + i) +: 8] = v[8*(PAYLOAD_BYTES - 1 - i) +: 8];
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] decode_slot(input logic [SLOT_W-1:0] slot,
			input logic [DATA_W-1:0] s);
		logic [VAL_W-1:0] r;
		case (slot)
			SLOT_STATUS:      r = {16'h0000, s[23:16], s[31:24]};
			SLOT_CURRENT:     r = {16'h0000, s[15:8], s[23:16]};
			SLOT_VOLTAGE:     r = {s[39:32], s[47:40], s[55:48], s[63:56]};
			SLOT_TEMPERATURE: r = {24'h000000, s[63:56]};
			default:          r = '0;
		endcase
		return r;
	endfunction

endpackage

[sv/cfc_id_regs.sv]
module cfc_id_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [cfc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [cfc_pkg::ID_W-1:0]      cfg_data,
	output logic                          cfg_ready,
	output cfc_pkg::id_bank_t             ids
);

	cfc_pkg::id_bank_t ids_q;

	assign cfg_ready = 1'b1;
	assign ids       = ids_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q <= cfc_pkg::ID_RESET;
		end else if (cfg_valid) begin
			ids_q[cfg_index] <= cfg_data;
		end
	end

endmodule

[sv/cfc_slot_store.sv]
module cfc_slot_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfc_pkg::slot_wr_t          wr,
	input  logic [cfc_pkg::SLOT_W-1:0] rd_slot,
	output logic [cfc_pkg::DATA_W-1:0] rd_data
);

	logic [cfc_pkg::SLOT_COUNT-1:0][cfc_pkg::DATA_W-1:0] payload_q;
	logic [cfc_pkg::SLOT_COUNT-1:0][cfc_pkg::TS_W-1:0]   ts_q;

	assign rd_data = payload_q[rd_slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= '1;
			ts_q      <= '0;
		end else if (wr.en) begin
			payload_q[wr.slot] <= wr.data;
			ts_q[wr.slot]      <= wr.ts;
		end
	end

endmodule

[sv/cfc_seq.sv]
module cfc_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [cfc_pkg::ID_W-1:0]   frame_id,
	input  logic [cfc_pkg::LEN_W-1:0]  frame_length,
	input  logic [cfc_pkg::DATA_W-1:0] payload,
	input  logic [cfc_pkg::TS_W-1:0]   timestamp,
	input  cfc_pkg::id_bank_t          ids,
	output logic [cfc_pkg::SLOT_W-1:0] rd_slot,
	input  logic [cfc_pkg::DATA_W-1:0] rd_data,
	output cfc_pkg::slot_wr_t          wr,
	output logic                       done,
	output logic [cfc_pkg::CODE_W-1:0] result_code,
	output logic [cfc_pkg::SLOT_W-1:0] matched_slot,
	output logic [cfc_pkg::VAL_W-1:0]  decoded_value
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	localparam logic [cfc_pkg::SLOT_W-1:0] LAST_SLOT =
		cfc_pkg::SLOT_W'(cfc_pkg::SLOT_COUNT - 1);

	logic [1:0]                   state_q;
	logic [cfc_pkg::SLOT_W-1:0]   idx_q;
	logic [cfc_pkg::ID_W-1:0]     id_q;
	logic [cfc_pkg::LEN_W-1:0]    len_q;
	logic [cfc_pkg::DATA_W-1:0]   swapped_q;
	logic [cfc_pkg::TS_W-1:0]     ts_q;
	logic                         done_q;
	logic [cfc_pkg::CODE_W-1:0]   code_q;
	logic [cfc_pkg::SLOT_W-1:0]   slot_q;
	logic [cfc_pkg::VAL_W-1:0]    value_q;
	logic                         id_hit;
	logic                         same;

	assign id_hit = (ids[idx_q] == id_q);
	assign same   = (rd_data == swapped_q);

	assign busy          = (state_q != ST_IDLE);
	assign rd_slot       = idx_q;
	assign done          = done_q;
	assign result_code   = code_q;
	assign matched_slot  = slot_q;
	assign decoded_value = value_q;

	assign wr.en   = (state_q == ST_CHECK) && (len_q == cfc_pkg::FULL_LENGTH) && !same;
	assign wr.slot = idx_q;
	assign wr.data = swapped_q;
	assign wr.ts   = ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (id_hit) begin
						state_q <= ST_CHECK;
					end else if (idx_q == LAST_SLOT) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CHECK: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			id_q      <= frame_id;
			len_q     <= frame_length;
			swapped_q <= cfc_pkg::swap_halves(payload);
			ts_q      <= timestamp;
		end
		if (state_q == ST_SCAN && !id_hit && idx_q == LAST_SLOT) begin
			code_q  <= cfc_pkg::RC_NO_MATCH;
			slot_q  <= '0;
			value_q <= '0;
		end
		if (state_q == ST_CHECK) begin
			slot_q <= idx_q;
			if (len_q != cfc_pkg::FULL_LENGTH) begin
				code_q  <= cfc_pkg::RC_BAD_LEN;
				value_q <= '0;
			end else if (same) begin
				code_q  <= cfc_pkg::RC_UNCHANGED;
				value_q <= '0;
			end else begin
				code_q  <= cfc_pkg::RC_UPDATED;
				value_q <= cfc_pkg::decode_slot(idx_q, swapped_q);
			end
		end
	end

endmodule

[sv/can_frame_change_filter.sv]
// Scans the slot identifiers through one shared compare, one slot per cycle.
// A frame is compared slot by slot until one matches; a match then passes through a check state, and done strobes.
// busy is high until the cycle done is high, so a new frame is taken only once the last is through.
// Reset: slot IDs return to defaults, stored payloads to all 0xFF, timestamps to 0.
// The receiver cannot stall: each result is on the ports for the single cycle done is high.
module can_frame_change_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cfc_pkg::ID_W-1:0]      frame_id,
	input  logic [cfc_pkg::LEN_W-1:0]     frame_length,
	input  logic [cfc_pkg::DATA_W-1:0]    payload,
	input  logic [cfc_pkg::TS_W-1:0]      timestamp,
	output logic                          done,
	output logic [cfc_pkg::CODE_W-1:0]    result_code,
	output logic [cfc_pkg::SLOT_W-1:0]    matched_slot,
	output logic [cfc_pkg::VAL_W-1:0]     decoded_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [cfc_pkg::ID_W-1:0]      cfg_data
);

	cfc_pkg::id_bank_t           ids;
	cfc_pkg::slot_wr_t           wr;
	logic [cfc_pkg::SLOT_W-1:0]  rd_slot;
	logic [cfc_pkg::DATA_W-1:0]  rd_data;

	cfc_id_regs u_id_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.ids       (ids)
	);

	cfc_slot_store u_slot_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_slot (rd_slot),
		.rd_data (rd_data)
	);

	cfc_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.frame_id      (frame_id),
		.frame_length  (frame_length),
		.payload       (payload),
		.timestamp     (timestamp),
		.ids           (ids),
		.rd_slot       (rd_slot),
		.rd_data       (rd_data),
		.wr            (wr),
		.done          (done),
		.result_code   (result_code),
		.matched_slot  (matched_slot),
		.decoded_value (decoded_value)
	);

endmodule

[verif/frame_outcome_checker.sv]
`timescale 1ns / 100ps
module frame_outcome_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [cfc_pkg::ID_W-1:0]      frame_id,
	input  logic [cfc_pkg::LEN_W-1:0]     frame_length,
	input  logic [cfc_pkg::DATA_W-1:0]    payload,
	input  logic [cfc_pkg::TS_W-1:0]      timestamp,
	input  logic                          done,
	input  logic [cfc_pkg::CODE_W-1:0]    result_code,
	input  logic [cfc_pkg::SLOT_W-1:0]    matched_slot,
	input  logic [cfc_pkg::VAL_W-1:0]     decoded_value,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [cfc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [cfc_pkg::ID_W-1:0]      cfg_data,
	output int                            outcomes_pending,
	output int                            mismatch_count
);

	localparam logic [cfc_pkg::REG_COUNT-1:0][cfc_pkg::ID_W-1:0] POWER_UP_IDS =
		{11'h488, 11'h388, 11'h288, 11'h188};

	typedef struct packed {
		logic [cfc_pkg::CODE_W-1:0] code;
		logic [cfc_pkg::SLOT_W-1:0] slot;
		logic [cfc_pkg::VAL_W-1:0]  value;
	} frame_outcome_t;

	logic [cfc_pkg::ID_W-1:0]   slot_id     [cfc_pkg::REG_COUNT];
	logic [cfc_pkg::DATA_W-1:0] stored_data [cfc_pkg::SLOT_COUNT];
	logic [cfc_pkg::TS_W-1:0]   stored_ts   [cfc_pkg::SLOT_COUNT];
	frame_outcome_t             expected_outcomes [$];
	int                         mismatches;

	function automatic logic [cfc_pkg::DATA_W-1:0] reorder_halves(
			input logic [cfc_pkg::DATA_W-1:0] d);
		return {d[39:32], d[47:40], d[55:48], d[63:56], d[7:0], d[15:8], d[23:16], d[31:24]};
	endfunction

	function automatic logic [cfc_pkg::VAL_W-1:0] field_of(
			input logic [cfc_pkg::SLOT_W-1:0] slot,
			input logic [cfc_pkg::DATA_W-1:0] s);
		case (slot)
			cfc_pkg::SLOT_STATUS:      return {16'h0000, s[23:16], s[31:24]};
			cfc_pkg::SLOT_CURRENT:     return {16'h0000, s[15:8], s[23:16]};
			cfc_pkg::SLOT_VOLTAGE:     return {s[39:32], s[47:40], s[55:48], s[63:56]};
			cfc_pkg::SLOT_TEMPERATURE: return {24'h000000, s[63:56]};
			default:                   return '0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic predict_frame(input logic [cfc_pkg::ID_W-1:0] id,
			input logic [cfc_pkg::LEN_W-1:0] len,
			input logic [cfc_pkg::DATA_W-1:0] data, input logic [cfc_pkg::TS_W-1:0] ts);
		frame_outcome_t             o;
		logic [cfc_pkg::DATA_W-1:0] swapped;
		int                         hit;
		hit = -1;
		o.code = cfc_pkg::RC_NO_MATCH;
		o.slot = '0;
		o.value = '0;
		for (int i = cfc_pkg::REG_COUNT - 1; i >= 0; i--) begin
			if (slot_id[i] == id) begin
				hit = i;
			end
		end
		if (hit >= 0) begin
			o.slot = cfc_pkg::SLOT_W'(hit);
			if (len != cfc_pkg::FULL_LENGTH) begin
				o.code = cfc_pkg::RC_BAD_LEN;
			end else begin
				swapped = reorder_halves(data);
				if (swapped == stored_data[hit]) begin
					o.code = cfc_pkg::RC_UNCHANGED;
				end else begin
					stored_data[hit] = swapped;
					stored_ts[hit] = ts;
					o.code = cfc_pkg::RC_UPDATED;
					o.value = field_of(o.slot, swapped);
				end
			end
		end
		expected_outcomes.push_back(o);
	endtask

	task automatic compare_outcome();
		frame_outcome_t want;
		if (expected_outcomes.size() == 0) begin
			report_mismatch("result with none pending", 64'(result_code), '0);
		end else begin
			want = expected_outcomes.pop_front();
			if (result_code !== want.code)
				report_mismatch("result_code", 64'(result_code), 64'(want.code));
			if (matched_slot !== want.slot)
				report_mismatch("matched_slot", 64'(matched_slot), 64'(want.slot));
			if (decoded_value !== want.value)
				report_mismatch("decoded_value", 64'(decoded_value), 64'(want.value));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cfc_pkg::REG_COUNT; i++) begin
				slot_id[i] = POWER_UP_IDS[i];
			end
			for (int i = 0; i < cfc_pkg::SLOT_COUNT; i++) begin
				stored_data[i] = '1;
				stored_ts[i] = '0;
			end
			expected_outcomes.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				compare_outcome();
			end
			if (cfg_valid && cfg_ready) begin
				slot_id[cfg_index] = cfg_data;
			end
			if (start && !busy) begin
				predict_frame(frame_id, frame_length, payload, timestamp);
			end
		end
		outcomes_pending <= expected_outcomes.size();
		mismatch_count <= mismatches;
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

	localparam logic [cfc_pkg::REG_COUNT-1:0][cfc_pkg::ID_W-1:0] POWER_UP_IDS =
		{11'h488, 11'h388, 11'h288, 11'h188};

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [cfc_pkg::ID_W-1:0]      frame_id;
	logic [cfc_pkg::LEN_W-1:0]     frame_length;
	logic [cfc_pkg::DATA_W-1:0]    payload;
	logic [cfc_pkg::TS_W-1:0]      timestamp;
	logic                          done;
	logic [cfc_pkg::CODE_W-1:0]    result_code;
	logic [cfc_pkg::SLOT_W-1:0]    matched_slot;
	logic [cfc_pkg::VAL_W-1:0]     decoded_value;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [cfc_pkg::REG_IDX_W-1:0] cfg_index;
	logic [cfc_pkg::ID_W-1:0]      cfg_data;
	int                            outcomes_pending;
	int                            mismatch_count;

	logic [cfc_pkg::ID_W-1:0]   active_ids [cfc_pkg::REG_COUNT];
	logic [cfc_pkg::DATA_W-1:0] last_payload_for [int];
	bit                         gaps_enabled;

	can_frame_change_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.frame_id      (frame_id),
		.frame_length  (frame_length),
		.payload       (payload),
		.timestamp     (timestamp),
		.done          (done),
		.result_code   (result_code),
		.matched_slot  (matched_slot),
		.decoded_value (decoded_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	frame_outcome_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.frame_id         (frame_id),
		.frame_length     (frame_length),
		.payload          (payload),
		.timestamp        (timestamp),
		.done             (done),
		.result_code      (result_code),
		.matched_slot     (matched_slot),
		.decoded_value    (decoded_value),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.outcomes_pending (outcomes_pending),
		.mismatch_count   (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	task automatic send_frame(input logic [cfc_pkg::ID_W-1:0] id,
			input logic [cfc_pkg::LEN_W-1:0] len,
			input logic [cfc_pkg::DATA_W-1:0] data, input logic [cfc_pkg::TS_W-1:0] ts);
		int gap;
		@(negedge clk);
		frame_id <= id;
		frame_length <= len;
		payload <= data;
		timestamp <= ts;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic quiesce();
		@(negedge clk) start <= 1'b0;
		while (outcomes_pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cfc_pkg::REG_IDX_W-1:0] idx,
			input logic [cfc_pkg::ID_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic program_ids(input logic [cfc_pkg::REG_COUNT-1:0][cfc_pkg::ID_W-1:0] ids);
		quiesce();
		for (int i = 0; i < cfc_pkg::REG_COUNT; i++) begin
			write_reg(cfc_pkg::REG_IDX_W'(i), ids[i]);
			active_ids[i] = ids[i];
		end
	endtask

	task automatic send_random_frame();
		logic [cfc_pkg::ID_W-1:0]   id;
		logic [cfc_pkg::LEN_W-1:0]  len;
		logic [cfc_pkg::DATA_W-1:0] data;
		int                         pick;
		int                         lane;
		if ($urandom_range(0, 99) < 70)
			id = active_ids[$urandom_range(0, cfc_pkg::REG_COUNT - 1)];
		else
			id = cfc_pkg::ID_W'($urandom);
		len = ($urandom_range(0, 99) < 85) ? cfc_pkg::FULL_LENGTH : cfc_pkg::LEN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 30 && last_payload_for.exists(int'(id))) begin
			data = last_payload_for[int'(id)];
		end else if (pick < 45 && last_payload_for.exists(int'(id))) begin
			data = last_payload_for[int'(id)];
			lane = $urandom_range(0, 7);
			data[8*lane +: 8] = 8'($urandom);
		end else if (pick < 50) begin
			data = '0;
		end else if (pick < 55) begin
			data = '1;
		end else begin
			data = {$urandom, $urandom};
		end
		if (len == cfc_pkg::FULL_LENGTH)
			last_payload_for[int'(id)] = data;
		send_frame(id, len, data, $urandom);
	endtask

	task automatic run_phase(input int count, input bit gaps);
		gaps_enabled = gaps;
		repeat (count) send_random_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		frame_id = '0;
		frame_length = '0;
		payload = '0;
		timestamp = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gaps_enabled = 1'b1;
		for (int i = 0; i < cfc_pkg::REG_COUNT; i++) begin
			active_ids[i] = POWER_UP_IDS[i];
		end
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send_frame(11'h188, cfc_pkg::FULL_LENGTH, '1, 32'h0000_0001);
		send_frame(11'h188, cfc_pkg::FULL_LENGTH, 64'h0123_4567_89AB_CDEF, 32'h0000_0000);
		send_frame(11'h188, cfc_pkg::FULL_LENGTH, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
		send_frame(11'h188, cfc_pkg::FULL_LENGTH, 64'h0123_4567_89AB_CD00, 32'h1234_5678);
		send_frame(11'h288, cfc_pkg::FULL_LENGTH, '0, 32'hFFFF_FFFF);
		send_frame(11'h288, cfc_pkg::FULL_LENGTH, '0, 32'h0000_0002);
		send_frame(11'h388, cfc_pkg::FULL_LENGTH, '1, 32'h0000_0003);
		send_frame(11'h388, cfc_pkg::FULL_LENGTH, 64'hFEDC_BA98_7654_3210, 32'h0000_0004);
		send_frame(11'h488, cfc_pkg::FULL_LENGTH, 64'h55AA_55AA_AA55_AA55, 32'h0000_0005);
		send_frame(11'h088, cfc_pkg::FULL_LENGTH, 64'h1111_2222_3333_4444, 32'h0000_0006);
		send_frame(11'h488, 4'd0, 64'h1111_2222_3333_4444, 32'h0000_0007);
		send_frame(11'h288, 4'd7, 64'h1111_2222_3333_4444, 32'h0000_0008);
		send_frame(11'h388, 4'd9, 64'h1111_2222_3333_4444, 32'h0000_0009);
		send_frame(11'h188, 4'd15, '0, 32'h0000_000A);
		send_frame(11'h000, cfc_pkg::FULL_LENGTH, 64'hDEAD_BEEF_CAFE_F00D, 32'h0000_000B);
		send_frame(11'h7FF, 4'd15, '1, 32'h0000_000C);
		send_frame(11'h123, 4'd0, '1, 32'h0000_000D);
		send_frame(11'h488, cfc_pkg::FULL_LENGTH, '1, 32'h0000_000E);
		send_frame(11'h488, cfc_pkg::FULL_LENGTH, '0, 32'h0000_000F);
		send_frame(11'h188, cfc_pkg::FULL_LENGTH, '1, 32'h8000_0000);

		run_phase(200, 1'b1);
		program_ids({11'h000, 11'h000, 11'h000, 11'h000});
		run_phase(150, 1'b1);
		program_ids({11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF});
		run_phase(150, 1'b1);
		program_ids({cfc_pkg::ID_W'($urandom), cfc_pkg::ID_W'($urandom),
			cfc_pkg::ID_W'($urandom), cfc_pkg::ID_W'($urandom)});
		run_phase(250, 1'b1);
		program_ids({cfc_pkg::ID_W'($urandom), 11'h555, cfc_pkg::ID_W'($urandom), 11'h555});
		run_phase(200, 1'b1);
		program_ids({11'h2AA, cfc_pkg::ID_W'($urandom), 11'h2AA, cfc_pkg::ID_W'($urandom)});
		run_phase(200, 1'b0);
		program_ids({cfc_pkg::ID_W'($urandom), cfc_pkg::ID_W'($urandom),
			cfc_pkg::ID_W'($urandom), cfc_pkg::ID_W'($urandom)});
		run_phase(200, 1'b1);
		program_ids(POWER_UP_IDS);
		run_phase(180, 1'b0);

		@(negedge clk) start <= 1'b0;
		for (int i = 0; i < 200 && outcomes_pending != 0; i++) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && outcomes_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
sv/cfc_pkg.sv
sv/cfc_id_regs.sv
sv/cfc_slot_store.sv
sv/cfc_seq.sv
sv/can_frame_change_filter.sv
verif/frame_outcome_checker.sv
verif/tb_top.sv
